[sv/esdiv_pkg.sv]
package esdiv_pkg;

  localparam int unsigned FIELD_W = 64;
  localparam int unsigned REM_W   = 63;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_DIV_ZERO = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [FIELD_W-1:0] dividend;
    logic signed [FIELD_W-1:0] divisor;
  } esdiv_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] quotient;
    logic        [REM_W-1:0]   remainder;
    status_e                   status;
  } esdiv_out_t;

endpackage

[sv/euclidean_signed_divider_core.sv]
// Euclidean signed divider, fully pipelined.
// Input channel in_valid_i / in_stall_o carries a dividend and a divisor;
// only the low DATA_WIDTH bits of each are used as two's complement values.
// Output channel out_valid_o / out_stall_i carries the quotient (sign-extended
// to 64 bits), the remainder (0 <= remainder < |divisor|) and a status:
// ok, division by zero, or quotient overflow (most negative dividend by -1).
// On error, quotient and remainder are zero.
// Pipeline stages, in order: one stage takes magnitudes and flags,
// DATA_WIDTH restoring-division stages each settle one quotient bit, one
// stage applies the Euclidean correction, and one stage restores the sign
// into the output register. One transaction is accepted per cycle while nothing stalls.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall_o rises in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits; the pipeline comes out of reset empty.
module euclidean_signed_divider_core
  import esdiv_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  esdiv_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output esdiv_out_t out_data_o
);

  localparam int unsigned DW = DATA_WIDTH;
  localparam logic [DW-1:0] ONE_DW  = {{(DW-1){1'b0}}, 1'b1};
  localparam logic [DW-1:0] SIGN_DW = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] ONES_DW = {DW{1'b1}};

  logic adv;

  // Front stage: magnitudes and special cases
  logic [DW-1:0] a_raw, b_raw, ua, ub;
  logic          a_neg, b_neg;
  status_e       st_in;

  // Division stages, index 0 is the front-stage register
  logic          val_q  [DW+1];
  logic [DW-1:0] rem_q  [DW+1];
  logic [DW-1:0] num_q  [DW+1];
  logic [DW-1:0] div_q  [DW+1];
  logic          aneg_q [DW+1];
  logic          qneg_q [DW+1];
  status_e       st_q   [DW+1];

  // Correction stage
  logic          fix_val_q;
  logic [DW-1:0] fix_quo_q, fix_rem_q;
  logic          fix_qneg_q;
  status_e       fix_st_q;
  logic [DW-1:0] fix_quo_d, fix_rem_d;
  logic          bump;

  // Output stage
  logic              out_valid_q;
  esdiv_out_t        out_data_q, out_data_d;
  logic signed [DW-1:0] quo_dw;

  // Hold everything while a finished result is stalled
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  always_comb begin
    a_raw = in_data_i.dividend[DW-1:0];
    b_raw = in_data_i.divisor[DW-1:0];
    a_neg = a_raw[DW-1];
    b_neg = b_raw[DW-1];
    ua    = a_neg ? (~a_raw + ONE_DW) : a_raw;
    ub    = b_neg ? (~b_raw + ONE_DW) : b_raw;
    if (b_raw == '0) begin
      st_in = STATUS_DIV_ZERO;
    end else if (a_raw == SIGN_DW && b_raw == ONES_DW) begin
      st_in = STATUS_OVERFLOW;
    end else begin
      st_in = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q[0] <= 1'b0;
    end else if (adv) begin
      val_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rem_q[0]  <= '0;
      num_q[0]  <= ua;
      div_q[0]  <= ub;
      aneg_q[0] <= a_neg;
      qneg_q[0] <= a_neg ^ b_neg;
      st_q[0]   <= st_in;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar k = 0; k < DW; k++) begin : g_div
    logic [DW-1:0] shifted;
    logic [DW:0]   diff;
    logic          ge;

    always_comb begin
      shifted = {rem_q[k][DW-2:0], num_q[k][DW-1]};
      diff    = {1'b0, shifted} - {1'b0, div_q[k]};
      ge      = !diff[DW];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        val_q[k+1] <= 1'b0;
      end else if (adv) begin
        val_q[k+1] <= val_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rem_q[k+1]  <= ge ? diff[DW-1:0] : shifted;
        num_q[k+1]  <= {num_q[k][DW-2:0], ge};
        div_q[k+1]  <= div_q[k];
        aneg_q[k+1] <= aneg_q[k];
        qneg_q[k+1] <= qneg_q[k];
        st_q[k+1]   <= st_q[k];
      end
    end
  end

  // Negative dividend with a nonzero rest: grow the magnitude, flip the rest
  always_comb begin
    bump      = aneg_q[DW] && (rem_q[DW] != '0);
    fix_quo_d = bump ? (num_q[DW] + ONE_DW) : num_q[DW];
    fix_rem_d = bump ? (div_q[DW] - rem_q[DW]) : rem_q[DW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fix_val_q <= 1'b0;
    end else if (adv) begin
      fix_val_q <= val_q[DW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fix_quo_q  <= fix_quo_d;
      fix_rem_q  <= fix_rem_d;
      fix_qneg_q <= qneg_q[DW];
      fix_st_q   <= st_q[DW];
    end
  end

  always_comb begin
    quo_dw = fix_qneg_q ? signed'(~fix_quo_q + ONE_DW) : signed'(fix_quo_q);
    out_data_d.status = fix_st_q;
    if (fix_st_q == STATUS_OK) begin
      out_data_d.quotient  = FIELD_W'(quo_dw);
      out_data_d.remainder = REM_W'(fix_rem_q);
    end else begin
      out_data_d.quotient  = '0;
      out_data_d.remainder = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= fix_val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench
  import esdiv_pkg::*;
;

  localparam int unsigned PIPE_DEPTH  = FIELD_W + 3;
  localparam int unsigned SETTLE_WAIT = 2 * PIPE_DEPTH;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned PHASE_ITEMS = 600;

  localparam logic [FIELD_W-1:0] S_MIN   = {1'b1, {(FIELD_W-1){1'b0}}};
  localparam logic [FIELD_W-1:0] S_MAX   = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam logic [FIELD_W-1:0] NEG_ONE = {FIELD_W{1'b1}};

  class division_scoreboard;
    esdiv_out_t  awaited_divisions[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned div_zero_seen;
    int unsigned overflow_seen;

    // Compute the Euclidean quotient and remainder of an accepted transaction.
    function void note_input(esdiv_in_t op);
      esdiv_out_t        res;
      logic [FIELD_W-1:0] a_raw;
      logic [FIELD_W-1:0] b_raw;
      logic [FIELD_W-1:0] a_mag;
      logic [FIELD_W-1:0] b_mag;
      logic [FIELD_W-1:0] q_mag;
      logic [FIELD_W-1:0] rest;
      logic               a_neg;
      logic               b_neg;
      a_raw = op.dividend;
      b_raw = op.divisor;
      a_neg = a_raw[FIELD_W-1];
      b_neg = b_raw[FIELD_W-1];
      a_mag = a_neg ? (~a_raw + 1'b1) : a_raw;
      b_mag = b_neg ? (~b_raw + 1'b1) : b_raw;
      res = '0;
      res.status = STATUS_OK;
      if (b_mag == '0) begin
        res.status = STATUS_DIV_ZERO;
      end else if (a_neg && a_mag == S_MIN && b_neg && b_mag == 1) begin
        res.status = STATUS_OVERFLOW;
      end else begin
        q_mag = a_mag / b_mag;
        rest  = a_mag % b_mag;
        // Negative dividend with a rest: step the quotient away from zero.
        if (a_neg && rest != '0) begin
          q_mag = q_mag + 1'b1;
          rest  = b_mag - rest;
        end
        res.quotient  = (a_neg != b_neg) ? (~q_mag + 1'b1) : q_mag;
        res.remainder = rest[REM_W-1:0];
      end
      awaited_divisions.push_back(res);
    endfunction

    function void check_result(esdiv_out_t got);
      esdiv_out_t want;
      if (awaited_divisions.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: q=%0d r=%0d status=%0d",
                   got.quotient, got.remainder, got.status);
        return;
      end
      want = awaited_divisions.pop_front();
      checked++;
      case (want.status)
        STATUS_DIV_ZERO: div_zero_seen++;
        STATUS_OVERFLOW: overflow_seen++;
        default: ;
      endcase
      if (got.quotient !== want.quotient || got.remainder !== want.remainder ||
          got.status !== want.status) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("mismatch on result %0d: expected q=%0d r=%0d status=%0d, got q=%0d r=%0d status=%0d",
                   checked, want.quotient, want.remainder, want.status,
                   got.quotient, got.remainder, got.status);
      end
    endfunction

    function int unsigned pending();
      return awaited_divisions.size();
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  esdiv_in_t  in_data_i;
  logic       out_valid_o;
  logic       out_stall_i;
  esdiv_out_t out_data_o;

  division_scoreboard board;
  int unsigned        send_idle_pct;
  int unsigned        recv_idle_pct;
  int unsigned        sent_count;
  int unsigned        cycle_count;

  euclidean_signed_divider_core #(
    .DATA_WIDTH(FIELD_W)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // Receiver: check accepted results, then pick the stall for the next edge.
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i)
        board.check_result(out_data_o);
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic push_division(input esdiv_in_t op);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= op;
    do @(posedge clk_i); while (in_stall_o);
    board.note_input(op);
    sent_count++;
  endtask

  // Hold off the sender until every awaited result has come back.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  function automatic logic [FIELD_W-1:0] random_operand();
    logic [FIELD_W-1:0] v;
    int unsigned        len;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      4, 5, 6: begin
        len = $urandom_range(1, FIELD_W - 1);
        v = v & ((64'd1 << len) - 1);
        if ($urandom_range(1) == 1) v = ~v + 1'b1;
      end
      7: v = 64'($urandom_range(0, 16)) - 64'd8;
      8: begin
        case ($urandom_range(0, 3))
          0: v = S_MIN;
          1: v = S_MAX;
          2: v = S_MIN + 1'b1;
          default: v = NEG_ONE;
        endcase
      end
      9: v = 64'($urandom_range(1, 1000));
      default: ;
    endcase
    return v;
  endfunction

  task automatic run_random_phase(input int unsigned n_items);
    esdiv_in_t          op;
    int unsigned        pick;
    logic [FIELD_W-1:0] scale;
    repeat (n_items) begin
      op.dividend = random_operand();
      op.divisor  = random_operand();
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        op.divisor = '0;
      end else if (pick < 5) begin
        op.dividend = S_MIN;
        op.divisor  = NEG_ONE;
      end else if (pick < 20) begin
        // Land on or right next to an exact multiple of the divisor.
        scale = 64'($urandom_range(0, 5000));
        if ($urandom_range(1) == 1) scale = ~scale + 1'b1;
        op.dividend = op.divisor * scale + 64'($urandom_range(0, 2)) - 64'd1;
      end
      push_division(op);
    end
  endtask

  initial begin
    esdiv_in_t directed_ops[$];
    board = new();
    sent_count    = 0;
    send_idle_pct = 33;
    recv_idle_pct = 57;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_ops.push_back({S_MAX, 64'sd1});
    directed_ops.push_back({S_MIN, 64'sd1});
    directed_ops.push_back({S_MIN, NEG_ONE});
    directed_ops.push_back({S_MIN, S_MIN});
    directed_ops.push_back({S_MAX, S_MAX});
    directed_ops.push_back({S_MIN, S_MAX});
    directed_ops.push_back({S_MAX, S_MIN});
    directed_ops.push_back({64'sd7, 64'sd0});
    directed_ops.push_back({64'sd0, 64'sd0});
    directed_ops.push_back({S_MIN, 64'sd0});
    directed_ops.push_back({64'sd0, 64'sd5});
    directed_ops.push_back({64'sd0, -64'sd5});
    directed_ops.push_back({64'sd7, 64'sd2});
    directed_ops.push_back({-64'sd7, 64'sd2});
    directed_ops.push_back({64'sd7, -64'sd2});
    directed_ops.push_back({-64'sd7, -64'sd2});
    directed_ops.push_back({-64'sd6, 64'sd3});
    directed_ops.push_back({-64'sd6, -64'sd3});
    directed_ops.push_back({NEG_ONE, S_MAX});
    directed_ops.push_back({NEG_ONE, S_MIN});
    directed_ops.push_back({64'sd1, S_MIN});
    directed_ops.push_back({S_MIN, 64'sd2});
    directed_ops.push_back({S_MIN, -64'sd2});
    directed_ops.push_back({S_MAX, NEG_ONE});
    directed_ops.push_back({NEG_ONE, NEG_ONE});
    foreach (directed_ops[i]) push_division(directed_ops[i]);
    wait_for_drain();

    run_random_phase(PHASE_ITEMS);
    wait_for_drain();

    send_idle_pct = 57;
    recv_idle_pct = 33;
    run_random_phase(PHASE_ITEMS);
    wait_for_drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase(PHASE_ITEMS);
    wait_for_drain();

    $display("run: %0d divisions sent, %0d results checked in %0d cycles",
             sent_count, board.checked, cycle_count);
    $display("run: %0d by zero, %0d overflow, three sender/receiver stall profiles",
             board.div_zero_seen, board.overflow_seen);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("%0d errors, %0d results still awaited", board.errors, board.pending());
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

[euclidean_signed_divider_core.f]
sv/esdiv_pkg.sv
sv/euclidean_signed_divider_core.sv
verif/testbench.sv
